[src/differential_drive_command_shaper_unit_assert.svh]
// Assertion macros shared by the command shaper modules.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef DIFFERENTIAL_DRIVE_COMMAND_SHAPER_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_COMMAND_SHAPER_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define DDCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define DDCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ddcs_pkg.sv]
`default_nettype none

package ddcs_pkg;

    // Event kinds carried on the input tuser
    localparam logic [2:0] KIND_ACCEL       = 3'd0;
    localparam logic [2:0] KIND_BRAKE       = 3'd1;
    localparam logic [2:0] KIND_LEFT        = 3'd2;
    localparam logic [2:0] KIND_RIGHT       = 3'd3;
    localparam logic [2:0] KIND_NONE        = 3'd4;
    localparam logic [2:0] KIND_BUMP_SENSOR = 3'd5;
    localparam logic [2:0] KIND_STOP        = 3'd6;
    localparam logic [2:0] KIND_BUMP_SPEED  = 3'd7;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPEED_STEP  = 1'b1;

    localparam int SPEED_LIMIT_BITS = 15;
    localparam int SPEED_STEP_BITS  = 10;
    localparam logic [SPEED_LIMIT_BITS-1:0] SPEED_LIMIT_RESET = 15'd400;
    localparam logic [SPEED_STEP_BITS-1:0]  SPEED_STEP_RESET  = 10'd50;

    // Drive command framing
    localparam logic [7:0]  OPCODE_DRIVE    = 8'd145;
    localparam logic [15:0] BUMP_SPEED_WORD = 16'd500;
    localparam int          BEAT_BITS       = 3;
    localparam logic [BEAT_BITS-1:0] BEAT_OPCODE  = 3'd0;
    localparam logic [BEAT_BITS-1:0] BEAT_RIGHT_H = 3'd1;
    localparam logic [BEAT_BITS-1:0] BEAT_RIGHT_L = 3'd2;
    localparam logic [BEAT_BITS-1:0] BEAT_LEFT_H  = 3'd3;
    localparam logic [BEAT_BITS-1:0] BEAT_LEFT_L  = 3'd4;

    // One drive command handed from the update logic to the link serializer
    typedef struct packed {
        logic        notice;
        logic [15:0] right_word;
        logic [15:0] left_word;
    } cmd_t;

endpackage

`default_nettype wire

[src/differential_drive_command_shaper_unit.sv]
// Differential-drive command shaper.
// Input channel s_*: one event per beat, event kind on s_tuser, bumper bits
// in s_tdata[1:0]. Output channel m_*: drive command runs of five bytes
// (opcode 145, right velocity high/low, left velocity high/low), bump notice
// on m_tuser, m_tlast on the fifth byte. Some events (latched idle, bump
// without bits) update state only and send no run.
// Configuration cfg_*: index 0 speed limit, index 1 speed step; always ready;
// users write it only while the block is idle; the block has no check of its own.
// Path: an accepted event is held in the input register until its run can be
// loaded; its first byte is valid the cycle after it leaves that register.
// Throughput: one byte per cycle on the link while m_tready is high; events
// that send nothing leave without a run. The next event is taken while a run
// is still draining.
// Reset: wheels and straight-line velocities zero, bump latch clear, speed
// limit 400, speed step 50, no run pending.
// Stall: a low m_tready holds the current byte; the input register then fills
// and s_tready drops until the run's last byte is taken.
`default_nettype none

`include "differential_drive_command_shaper_unit_assert.svh"

module differential_drive_command_shaper_unit
    import ddcs_pkg::*;
#(
    parameter int VELOCITY_BITS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,    // bump_bits[1:0], zero pad [7:2]
    input  logic [2:0]                s_tuser,    // kind[2:0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [7:0]                m_tdata,    // link_byte[7:0]
    output logic                      m_tuser,    // bump_notice[0]
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SPEED_LIMIT_BITS-1:0] cfg_data
);

    logic                            in_valid_reg;
    logic [2:0]                      kind_reg;
    logic [1:0]                      bits_reg;
    logic signed [VELOCITY_BITS-1:0] left_vel_reg;
    logic signed [VELOCITY_BITS-1:0] right_vel_reg;
    logic signed [VELOCITY_BITS-1:0] left_str_reg;
    logic signed [VELOCITY_BITS-1:0] right_str_reg;
    logic                            bump_latch_reg;
    logic [SPEED_LIMIT_BITS-1:0]     speed_limit_reg;
    logic [SPEED_STEP_BITS-1:0]      speed_step_reg;
    logic signed [VELOCITY_BITS-1:0] left_vel_next;
    logic signed [VELOCITY_BITS-1:0] right_vel_next;
    logic signed [VELOCITY_BITS-1:0] left_str_next;
    logic signed [VELOCITY_BITS-1:0] right_str_next;
    logic                            bump_latch_next;
    logic                            emit;
    cmd_t                            cmd;
    logic                            tx_free;
    logic                            advance;

    // Event leaves the input register once its run can be loaded, or whenever it sends no run
    assign advance  = in_valid_reg && (!emit || tx_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            kind_reg <= s_tuser;
            bits_reg <= s_tdata[1:0];
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= SPEED_LIMIT_RESET;
            speed_step_reg  <= SPEED_STEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                CFG_SPEED_STEP:  speed_step_reg  <= cfg_data[SPEED_STEP_BITS-1:0];
                default:         speed_limit_reg <= speed_limit_reg;
            endcase
        end
    end

    ddcs_step #(
        .VELOCITY_BITS (VELOCITY_BITS)
    ) u_step (
        .kind            (kind_reg),
        .bump_bits       (bits_reg),
        .left_vel        (left_vel_reg),
        .right_vel       (right_vel_reg),
        .left_str        (left_str_reg),
        .right_str       (right_str_reg),
        .bump_latch      (bump_latch_reg),
        .speed_limit     (speed_limit_reg),
        .speed_step      (speed_step_reg),
        .left_vel_next   (left_vel_next),
        .right_vel_next  (right_vel_next),
        .left_str_next   (left_str_next),
        .right_str_next  (right_str_next),
        .bump_latch_next (bump_latch_next),
        .emit            (emit),
        .cmd             (cmd)
    );

    // Wheel state advances with each event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_vel_reg   <= '0;
            right_vel_reg  <= '0;
            left_str_reg   <= '0;
            right_str_reg  <= '0;
            bump_latch_reg <= 1'b0;
        end
        else if (advance)
        begin
            left_vel_reg   <= left_vel_next;
            right_vel_reg  <= right_vel_next;
            left_str_reg   <= left_str_next;
            right_str_reg  <= right_str_next;
            bump_latch_reg <= bump_latch_next;
        end
    end

    ddcs_tx u_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && emit),
        .cmd      (cmd),
        .free     (tx_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `DDCS_ASSERT_NEXT(a_accept_fills_input, s_tvalid && s_tready, in_valid_reg, "accepted beat lost")
    `DDCS_ASSERT_NEXT(a_bump_speed_latches, advance && kind_reg == KIND_BUMP_SPEED, bump_latch_reg, "bump speed did not latch")
    `DDCS_ASSERT_NEXT(a_stop_clears, advance && kind_reg == KIND_STOP, left_vel_reg == '0 && right_vel_reg == '0, "stop left wheels moving")
    `DDCS_ASSERT_SAME(a_emit_waits_link, advance && emit, tx_free, "run loaded while link busy")

endmodule

`default_nettype wire

[src/ddcs_step.sv]
`default_nettype none

module ddcs_step
    import ddcs_pkg::*;
#(
    parameter int VELOCITY_BITS = 16
)
(
    input  logic [2:0]                      kind,
    input  logic [1:0]                      bump_bits,
    input  logic signed [VELOCITY_BITS-1:0] left_vel,
    input  logic signed [VELOCITY_BITS-1:0] right_vel,
    input  logic signed [VELOCITY_BITS-1:0] left_str,
    input  logic signed [VELOCITY_BITS-1:0] right_str,
    input  logic                            bump_latch,
    input  logic [SPEED_LIMIT_BITS-1:0]     speed_limit,
    input  logic [SPEED_STEP_BITS-1:0]      speed_step,
    output logic signed [VELOCITY_BITS-1:0] left_vel_next,
    output logic signed [VELOCITY_BITS-1:0] right_vel_next,
    output logic signed [VELOCITY_BITS-1:0] left_str_next,
    output logic signed [VELOCITY_BITS-1:0] right_str_next,
    output logic                            bump_latch_next,
    output logic                            emit,
    output cmd_t                            cmd
);

    localparam int CMP_BITS = ((VELOCITY_BITS > 16) ? VELOCITY_BITS : 16) + 1;
    localparam int STEP_PAD = VELOCITY_BITS - SPEED_STEP_BITS;

    logic signed [CMP_BITS-1:0]      lv_w;
    logic signed [CMP_BITS-1:0]      rv_w;
    logic signed [CMP_BITS-1:0]      lim_pos;
    logic signed [CMP_BITS-1:0]      lim_neg;
    logic signed [CMP_BITS-1:0]      nlv_w;
    logic signed [CMP_BITS-1:0]      nrv_w;
    logic [VELOCITY_BITS-1:0]        step_v;
    logic [VELOCITY_BITS-1:0]        step2_v;
    logic signed [VELOCITY_BITS-1:0] vmax;
    logic                            lv_below;
    logic                            rv_below;
    logic                            lv_above;
    logic                            rv_above;
    logic                            left_turn_inside;
    logic                            right_turn_inside;
    logic                            speed_cmd;
    logic                            notice;

    // Widen wheels and limit so the compares never overflow
    assign lv_w    = {{(CMP_BITS-VELOCITY_BITS){left_vel[VELOCITY_BITS-1]}}, left_vel};
    assign rv_w    = {{(CMP_BITS-VELOCITY_BITS){right_vel[VELOCITY_BITS-1]}}, right_vel};
    assign lim_pos = {{(CMP_BITS-SPEED_LIMIT_BITS){1'b0}}, speed_limit};
    assign lim_neg = -lim_pos;

    assign step_v  = {{STEP_PAD{1'b0}}, speed_step};
    assign step2_v = {step_v[VELOCITY_BITS-2:0], 1'b0};

    assign lv_below = lv_w < lim_pos;
    assign rv_below = rv_w < lim_pos;
    assign lv_above = lv_w > lim_neg;
    assign rv_above = rv_w > lim_neg;

    // A wheel is inside the band when its magnitude is below the limit
    assign left_turn_inside  = rv_w[CMP_BITS-1] ? rv_above : rv_below;
    assign right_turn_inside = lv_w[CMP_BITS-1] ? lv_above : lv_below;

    assign vmax = (left_vel > right_vel) ? left_vel : right_vel;

    // Apply one event to the wheel state
    always_comb
    begin
        left_vel_next   = left_vel;
        right_vel_next  = right_vel;
        left_str_next   = left_str;
        right_str_next  = right_str;
        bump_latch_next = bump_latch;
        emit            = 1'b0;
        notice          = 1'b0;
        speed_cmd       = 1'b0;
        unique case (kind)
            KIND_BUMP_SENSOR:
            begin
                if (bump_bits != 2'b00)
                begin
                    bump_latch_next = 1'b1;
                    left_vel_next   = '0;
                    right_vel_next  = '0;
                    left_str_next   = '0;
                    right_str_next  = '0;
                    emit            = 1'b1;
                    notice          = 1'b1;
                end
            end
            KIND_STOP:
            begin
                left_vel_next  = '0;
                right_vel_next = '0;
                left_str_next  = '0;
                right_str_next = '0;
                emit           = 1'b1;
            end
            KIND_BUMP_SPEED:
            begin
                bump_latch_next = 1'b1;
                emit            = 1'b1;
                speed_cmd       = 1'b1;
            end
            default:
            begin
                priority if (kind == KIND_ACCEL && lv_below && rv_below)
                begin
                    // Equalize first, step up only once both wheels agree
                    bump_latch_next = 1'b0;
                    if (left_vel != right_vel)
                    begin
                        left_vel_next  = vmax;
                        right_vel_next = vmax;
                    end
                    else
                    begin
                        left_vel_next  = left_vel + step_v;
                        right_vel_next = left_vel + step_v;
                    end
                    left_str_next  = left_vel_next;
                    right_str_next = right_vel_next;
                end
                else if (kind == KIND_BRAKE && lv_above && rv_above)
                begin
                    bump_latch_next = 1'b0;
                    left_vel_next   = vmax - step_v;
                    right_vel_next  = vmax - step_v;
                    left_str_next   = left_vel_next;
                    right_str_next  = right_vel_next;
                end
                else if (kind == KIND_LEFT)
                begin
                    bump_latch_next = 1'b0;
                    if (left_turn_inside)
                    begin
                        left_vel_next  = left_vel - step_v;
                        right_vel_next = right_vel + step_v;
                    end
                    else
                    begin
                        left_vel_next = left_vel - step2_v;
                    end
                end
                else if (kind == KIND_RIGHT)
                begin
                    bump_latch_next = 1'b0;
                    if (right_turn_inside)
                    begin
                        left_vel_next  = left_vel + step_v;
                        right_vel_next = right_vel - step_v;
                    end
                    else
                    begin
                        right_vel_next = right_vel - step2_v;
                    end
                end
                else if (!bump_latch)
                begin
                    // Ease back toward the straight-line velocities
                    if (left_vel >= left_str && right_vel < right_str)
                    begin
                        if (left_vel == left_str)
                        begin
                            right_vel_next = right_vel + step2_v;
                        end
                        else
                        begin
                            left_vel_next  = left_vel - step_v;
                            right_vel_next = right_vel + step_v;
                        end
                    end
                    else if (left_vel < left_str && right_vel >= right_str)
                    begin
                        if (right_vel == right_str)
                        begin
                            left_vel_next = left_vel + step2_v;
                        end
                        else
                        begin
                            left_vel_next  = left_vel + step_v;
                            right_vel_next = right_vel - step_v;
                        end
                    end
                    else
                    begin
                        left_vel_next  = left_str;
                        right_vel_next = right_str;
                    end
                end
                else
                begin
                    // Latched: hold the wheels
                    left_vel_next  = left_vel;
                    right_vel_next = right_vel;
                end
                emit = !bump_latch_next;
            end
        endcase
    end

    // Sign-extend the new wheels and send their low 16 bits
    assign nlv_w = {{(CMP_BITS-VELOCITY_BITS){left_vel_next[VELOCITY_BITS-1]}}, left_vel_next};
    assign nrv_w = {{(CMP_BITS-VELOCITY_BITS){right_vel_next[VELOCITY_BITS-1]}},
                    right_vel_next};

    assign cmd = '{notice:     notice,
                   right_word: (speed_cmd ? BUMP_SPEED_WORD : nrv_w[15:0]),
                   left_word:  (speed_cmd ? BUMP_SPEED_WORD : nlv_w[15:0])};

endmodule

`default_nettype wire

[src/ddcs_tx.sv]
`default_nettype none

`include "differential_drive_command_shaper_unit_assert.svh"

module ddcs_tx
    import ddcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  cmd_t       cmd,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // link_byte[7:0]
    output logic       m_tuser,   // bump_notice[0]
    output logic       m_tlast
);

    cmd_t                 cmd_reg;
    logic                 busy_reg;
    logic [BEAT_BITS-1:0] beat_reg;
    logic                 beat_done;
    logic                 run_done;

    assign beat_done = busy_reg && m_tready;
    assign run_done  = beat_done && (beat_reg == BEAT_LEFT_L);
    assign free      = !busy_reg || run_done;

    // Load a new command or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_OPCODE;
        end
        else if (load && free)
        begin
            busy_reg <= 1'b1;
            beat_reg <= BEAT_OPCODE;
        end
        else if (run_done)
        begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_OPCODE;
        end
        else if (beat_done)
        begin
            beat_reg <= beat_reg + 1'b1;
        end
    end

    // Hold the command words for the whole run
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            cmd_reg <= cmd;
        end
    end

    // Select the byte for the current beat
    always_comb
    begin
        unique case (beat_reg)
            BEAT_OPCODE:  m_tdata = OPCODE_DRIVE;
            BEAT_RIGHT_H: m_tdata = cmd_reg.right_word[15:8];
            BEAT_RIGHT_L: m_tdata = cmd_reg.right_word[7:0];
            BEAT_LEFT_H:  m_tdata = cmd_reg.left_word[15:8];
            BEAT_LEFT_L:  m_tdata = cmd_reg.left_word[7:0];
            default:      m_tdata = OPCODE_DRIVE;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = cmd_reg.notice;
    assign m_tlast  = beat_reg == BEAT_LEFT_L;

    `DDCS_ASSERT_NEXT(a_run_opens_with_opcode, load && free, m_tvalid && m_tdata == OPCODE_DRIVE, "run does not start with opcode")
    `DDCS_ASSERT_NEXT(a_run_ends_idle, run_done && !load, !m_tvalid, "valid held past final beat")
    `DDCS_ASSERT_NEXT(a_notice_steady, beat_done && !m_tlast, m_tuser == $past(m_tuser), "notice changed within run")

endmodule

`default_nettype wire
